// ----- src/fir_pkg.sv -----
// Shared constants and helpers for the fast inverse square root pipeline.
// No dependencies; used by fir_fmul, fir_fadd and fast_inverse_sqrt.
`timescale 1ns / 1ps
package fir_pkg;

   localparam logic [31:0] MAGIC        = 32'h5f3759df;
   localparam logic [31:0] ONE_HALF     = 32'h3f000000;
   localparam logic [31:0] THREE_HALVES = 32'h3fc00000;
   localparam logic [31:0] CANON_QNAN   = 32'h7fc00000;
   localparam logic [7:0]  EXP_MAX      = 8'hff;

   // pipeline depths
   localparam int unsigned UNIT_STAGES = 3;
   localparam int unsigned GUESS_DEPTH = 4 * UNIT_STAGES;
   localparam int unsigned LATENCY     = 5 * UNIT_STAGES + 1;

   // count leading zeros of a 48-bit word, 48 when the word is zero
   function automatic logic [5:0] lzc48(input logic [47:0] v);
      logic [5:0] n;
      n = 6'd48;
      for (int i = 0; i < 48; i++) begin
         if (v[i]) n = 6'(47 - i);
      end
      return n;
   endfunction

endpackage

// ----- src/fir_fmul.sv -----
// Three-stage binary32 multiplier, round to nearest even, subnormals kept.
// Depends on fir_pkg.
`timescale 1ns / 1ps
module fir_fmul (
   input  logic        clock,
   input  logic [31:0] a_bits,
   input  logic [31:0] b_bits,
   output logic [31:0] y_bits
);

   // stage 1: unpack, classify, multiply significands
   logic [7:0]  ea, eb;
   logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
   logic [23:0] ma, mb;
   logic [7:0]  eae, ebe;

   logic        s1_nan_ff, s1_inf_ff, s1_zero_ff, s1_sign_ff;
   logic [47:0] s1_prod_ff;
   logic [8:0]  s1_esum_ff;

   always_comb begin
      ea     = a_bits[30:23];
      eb     = b_bits[30:23];
      a_nan  = (ea == fir_pkg::EXP_MAX) && (a_bits[22:0] != 23'd0);
      b_nan  = (eb == fir_pkg::EXP_MAX) && (b_bits[22:0] != 23'd0);
      a_inf  = (ea == fir_pkg::EXP_MAX) && (a_bits[22:0] == 23'd0);
      b_inf  = (eb == fir_pkg::EXP_MAX) && (b_bits[22:0] == 23'd0);
      a_zero = (ea == 8'd0) && (a_bits[22:0] == 23'd0);
      b_zero = (eb == 8'd0) && (b_bits[22:0] == 23'd0);
      ma     = {ea != 8'd0, a_bits[22:0]};
      mb     = {eb != 8'd0, b_bits[22:0]};
      eae    = (ea == 8'd0) ? 8'd1 : ea;
      ebe    = (eb == 8'd0) ? 8'd1 : eb;
   end

   always_ff @(posedge clock) begin
      s1_nan_ff  <= a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
      s1_inf_ff  <= a_inf || b_inf;
      s1_zero_ff <= a_zero || b_zero;
      s1_sign_ff <= a_bits[31] ^ b_bits[31];
      s1_prod_ff <= ma * mb;
      s1_esum_ff <= {1'b0, eae} + {1'b0, ebe};
   end

   // stage 2: normalize left, work out exponent and right shift
   logic [5:0]         lz;
   logic signed [10:0] e_norm, e_diff;
   logic [47:0]        norm_in;
   logic [5:0]         sh_in;
   logic [9:0]         exp_in;

   logic        s2_nan_ff, s2_inf_ff, s2_zero_ff, s2_sign_ff;
   logic [47:0] s2_norm_ff;
   logic [5:0]  s2_sh_ff;
   logic [9:0]  s2_exp_ff;

   always_comb begin
      lz      = fir_pkg::lzc48(s1_prod_ff);
      norm_in = s1_prod_ff << lz;
      e_norm  = $signed({2'b00, s1_esum_ff}) - $signed({5'd0, lz}) - 11'sd126;
      e_diff  = 11'sd25 - e_norm;
      if (e_norm > 11'sd0) begin
         sh_in  = 6'd24;
         exp_in = e_norm[9:0];
      end else begin
         sh_in  = (e_diff > 11'sd63) ? 6'd63 : e_diff[5:0];
         exp_in = 10'd1;
      end
   end

   always_ff @(posedge clock) begin
      s2_nan_ff  <= s1_nan_ff;
      s2_inf_ff  <= s1_inf_ff;
      s2_zero_ff <= s1_zero_ff || (s1_prod_ff == 48'd0);
      s2_sign_ff <= s1_sign_ff;
      s2_norm_ff <= norm_in;
      s2_sh_ff   <= sh_in;
      s2_exp_ff  <= exp_in;
   end

   // stage 3: shift, round, pack
   logic [63:0] ext, shifted, below;
   logic [5:0]  shm1;
   logic        guard, sticky, inc;
   logic [24:0] q_rnd;
   logic [23:0] mant;
   logic [9:0]  exp_fin;
   logic [31:0] y_in;
   logic [31:0] y_ff;

   always_comb begin
      ext     = {16'd0, s2_norm_ff};
      shm1    = s2_sh_ff - 6'd1;
      shifted = ext >> s2_sh_ff;
      below   = ext >> shm1;
      guard   = below[0];
      sticky  = |(ext & ((64'd1 << shm1) - 64'd1));
      inc     = guard && (sticky || shifted[0]);
      q_rnd   = {1'b0, shifted[23:0]} + {24'd0, inc};
      if (q_rnd[24]) begin
         mant    = q_rnd[24:1];
         exp_fin = s2_exp_ff + 10'd1;
      end else begin
         mant    = q_rnd[23:0];
         exp_fin = s2_exp_ff;
      end
      if (s2_nan_ff) begin
         y_in = fir_pkg::CANON_QNAN;
      end else if (s2_inf_ff || (exp_fin >= 10'd255)) begin
         y_in = {s2_sign_ff, fir_pkg::EXP_MAX, 23'd0};
      end else if (s2_zero_ff) begin
         y_in = {s2_sign_ff, 31'd0};
      end else begin
         y_in = {s2_sign_ff, mant[23] ? exp_fin[7:0] : 8'd0, mant[22:0]};
      end
   end

   always_ff @(posedge clock) begin
      y_ff <= y_in;
   end

   assign y_bits = y_ff;

endmodule

// ----- src/fir_fadd.sv -----
// Three-stage binary32 adder, round to nearest even, subnormals kept.
// Depends on fir_pkg.
`timescale 1ns / 1ps
module fir_fadd (
   input  logic        clock,
   input  logic [31:0] a_bits,
   input  logic [31:0] b_bits,
   output logic [31:0] y_bits
);

   // stage 1: classify, order by magnitude, align the smaller operand
   logic [7:0]  ea, eb, ebig, esml, d;
   logic        a_nan, b_nan, a_inf, b_inf, a_big;
   logic [31:0] big, sml;
   logic [26:0] bigm, smlm, sml_sh, sml_al;
   logic        sml_st;

   logic        s1_nan_ff, s1_inf_ff, s1_isign_ff, s1_zsign_ff;
   logic        s1_sign_ff, s1_sub_ff;
   logic [26:0] s1_bigm_ff, s1_smlm_ff;
   logic [7:0]  s1_exp_ff;

   always_comb begin
      ea     = a_bits[30:23];
      eb     = b_bits[30:23];
      a_nan  = (ea == fir_pkg::EXP_MAX) && (a_bits[22:0] != 23'd0);
      b_nan  = (eb == fir_pkg::EXP_MAX) && (b_bits[22:0] != 23'd0);
      a_inf  = (ea == fir_pkg::EXP_MAX) && (a_bits[22:0] == 23'd0);
      b_inf  = (eb == fir_pkg::EXP_MAX) && (b_bits[22:0] == 23'd0);
      a_big  = a_bits[30:0] >= b_bits[30:0];
      big    = a_big ? a_bits : b_bits;
      sml    = a_big ? b_bits : a_bits;
      ebig   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      esml   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
      d      = ebig - esml;
      bigm   = {big[30:23] != 8'd0, big[22:0], 3'b000};
      smlm   = {sml[30:23] != 8'd0, sml[22:0], 3'b000};
      if (d >= 8'd27) begin
         sml_sh = 27'd0;
         sml_st = |smlm;
      end else begin
         sml_sh = smlm >> d;
         sml_st = |(smlm & ((27'd1 << d) - 27'd1));
      end
      sml_al = {sml_sh[26:1], sml_sh[0] | sml_st};
   end

   always_ff @(posedge clock) begin
      s1_nan_ff   <= a_nan || b_nan || (a_inf && b_inf && (a_bits[31] != b_bits[31]));
      s1_inf_ff   <= a_inf || b_inf;
      s1_isign_ff <= a_inf ? a_bits[31] : b_bits[31];
      s1_zsign_ff <= a_bits[31] & b_bits[31];
      s1_sign_ff  <= big[31];
      s1_sub_ff   <= a_bits[31] != b_bits[31];
      s1_bigm_ff  <= bigm;
      s1_smlm_ff  <= sml_al;
      s1_exp_ff   <= ebig;
   end

   // stage 2: add or subtract, normalize
   logic [27:0] sum;
   logic [5:0]  lz;
   logic [8:0]  lsh_a, lsh_b, lsh;
   logic [26:0] norm_in;
   logic [9:0]  exp_in;

   logic        s2_nan_ff, s2_inf_ff, s2_isign_ff, s2_zsign_ff, s2_sign_ff, s2_zero_ff;
   logic [26:0] s2_norm_ff;
   logic [9:0]  s2_exp_ff;

   always_comb begin
      if (s1_sub_ff) sum = {1'b0, s1_bigm_ff} - {1'b0, s1_smlm_ff};
      else           sum = {1'b0, s1_bigm_ff} + {1'b0, s1_smlm_ff};
      lz    = fir_pkg::lzc48({sum, 20'd0});
      lsh_a = {3'd0, lz} - 9'd1;
      lsh_b = {1'b0, s1_exp_ff} - 9'd1;
      lsh   = (lsh_a < lsh_b) ? lsh_a : lsh_b;
      if (lz == 6'd0) begin
         norm_in = {sum[27:2], sum[1] | sum[0]};
         exp_in  = {2'b00, s1_exp_ff} + 10'd1;
      end else begin
         norm_in = sum[26:0] << lsh;
         exp_in  = {2'b00, s1_exp_ff} - {1'b0, lsh};
      end
   end

   always_ff @(posedge clock) begin
      s2_nan_ff   <= s1_nan_ff;
      s2_inf_ff   <= s1_inf_ff;
      s2_isign_ff <= s1_isign_ff;
      s2_zsign_ff <= s1_zsign_ff;
      s2_sign_ff  <= s1_sign_ff;
      s2_zero_ff  <= sum == 28'd0;
      s2_norm_ff  <= norm_in;
      s2_exp_ff   <= exp_in;
   end

   // stage 3: round, pack
   logic        inc;
   logic [24:0] q_rnd;
   logic [23:0] mant;
   logic [9:0]  exp_fin;
   logic [31:0] y_in;
   logic [31:0] y_ff;

   always_comb begin
      inc   = s2_norm_ff[2] && ((|s2_norm_ff[1:0]) || s2_norm_ff[3]);
      q_rnd = {1'b0, s2_norm_ff[26:3]} + {24'd0, inc};
      if (q_rnd[24]) begin
         mant    = q_rnd[24:1];
         exp_fin = s2_exp_ff + 10'd1;
      end else begin
         mant    = q_rnd[23:0];
         exp_fin = s2_exp_ff;
      end
      if (s2_nan_ff) begin
         y_in = fir_pkg::CANON_QNAN;
      end else if (s2_inf_ff) begin
         y_in = {s2_isign_ff, fir_pkg::EXP_MAX, 23'd0};
      end else if (s2_zero_ff) begin
         y_in = {s2_zsign_ff, 31'd0};
      end else if (exp_fin >= 10'd255) begin
         y_in = {s2_sign_ff, fir_pkg::EXP_MAX, 23'd0};
      end else begin
         y_in = {s2_sign_ff, mant[23] ? exp_fin[7:0] : 8'd0, mant[22:0]};
      end
   end

   always_ff @(posedge clock) begin
      y_ff <= y_in;
   end

   assign y_bits = y_ff;

endmodule

// ----- src/fast_inverse_sqrt.sv -----
// Top level of the fast inverse square root pipeline.
// Depends on fir_pkg, fir_fmul and fir_fadd.
`timescale 1ns / 1ps
// Usage:
//   Drive req_operand_bits (binary32 raw bits) and raise start; the word is
//   taken at any rising edge where start is high and busy is low. busy stays
//   low: the pipeline takes one word every cycle with no gaps.
//   Each word returns on rsp_result_bits with rsp_strobe high for a single
//   cycle alongside it. Results leave in the order taken.
//   The datapath is five floating-point units of three stages each
//   (0.5*x, half*g, t1*g, 1.5-t2, g*t3) plus the output register that folds
//   any NaN to the canonical quiet NaN.
//   The first guess g comes straight from the operand word (magic constant
//   minus the operand shifted right arithmetically) and rides a delay line
//   beside the units until each multiply needs it.
//   Reset clears the valid line, so no strobe appears for words in flight.
//   The receiver cannot hold results off, so nothing here ever stalls;
//   a valid bit travels with every word through all stages.
module fast_inverse_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_operand_bits,
   output logic        rsp_strobe,
   output logic [31:0] rsp_result_bits
);

   logic [31:0] g_in;
   logic [31:0] g_ff [fir_pkg::GUESS_DEPTH];
   logic        valid_ff [fir_pkg::LATENCY];
   logic [31:0] half_bits, t1_bits, t2_bits, t3_bits, r_bits;
   logic [31:0] result_in, result_ff;

   assign busy = 1'b0;

   // first guess from the raw word
   assign g_in = fir_pkg::MAGIC - {req_operand_bits[31], req_operand_bits[31:1]};

   // hold g beside the arithmetic until each multiply needs it
   always_ff @(posedge clock) begin
      g_ff[0] <= g_in;
      for (int i = 1; i < fir_pkg::GUESS_DEPTH; i++) begin
         g_ff[i] <= g_ff[i-1];
      end
   end

   // advance the valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < fir_pkg::LATENCY; i++) valid_ff[i] <= 1'b0;
      end else begin
         valid_ff[0] <= start && !busy;
         for (int i = 1; i < fir_pkg::LATENCY; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   fir_fmul u_half (
      .clock  (clock),
      .a_bits (req_operand_bits),
      .b_bits (fir_pkg::ONE_HALF),
      .y_bits (half_bits)
   );

   fir_fmul u_t1 (
      .clock  (clock),
      .a_bits (half_bits),
      .b_bits (g_ff[fir_pkg::UNIT_STAGES - 1]),
      .y_bits (t1_bits)
   );

   fir_fmul u_t2 (
      .clock  (clock),
      .a_bits (t1_bits),
      .b_bits (g_ff[2 * fir_pkg::UNIT_STAGES - 1]),
      .y_bits (t2_bits)
   );

   // 1.5 - t2: add with the sign of t2 flipped
   fir_fadd u_t3 (
      .clock  (clock),
      .a_bits (fir_pkg::THREE_HALVES),
      .b_bits ({~t2_bits[31], t2_bits[30:0]}),
      .y_bits (t3_bits)
   );

   fir_fmul u_r (
      .clock  (clock),
      .a_bits (g_ff[fir_pkg::GUESS_DEPTH - 1]),
      .b_bits (t3_bits),
      .y_bits (r_bits)
   );

   // fold every NaN to the canonical quiet NaN
   always_comb begin
      if ((r_bits[30:23] == fir_pkg::EXP_MAX) && (r_bits[22:0] != 23'd0)) begin
         result_in = fir_pkg::CANON_QNAN;
      end else begin
         result_in = r_bits;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_strobe      = valid_ff[fir_pkg::LATENCY - 1];
   assign rsp_result_bits = result_ff;

   // a taken word comes back exactly one latency later
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##(fir_pkg::LATENCY) rsp_strobe)
      else $error("result strobe missing after accepted word");

   // no strobe right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("strobe right after reset");

   // no non-canonical NaN leaves the block
   a_canon_nan: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_result_bits[30:23] == fir_pkg::EXP_MAX)
      && (rsp_result_bits[22:0] != 23'd0) |-> rsp_result_bits == fir_pkg::CANON_QNAN)
      else $error("non-canonical NaN on result");

   // a strobe only follows a word taken one latency earlier
   a_no_ghost: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, fir_pkg::LATENCY))
      else $error("strobe without a matching accepted word");

endmodule

// ----- bench/fir_checker.sv -----
// Checker for the fast inverse square root block: watches the request and
// result channels, predicts each result and compares. Depends on fir_pkg.
`timescale 1ns / 1ps
module fir_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [31:0] req_operand_bits,
   input  logic        rsp_strobe,
   input  logic [31:0] rsp_result_bits,
   output int          errors,
   output int          pending,
   output int          checked
);

   logic [31:0] rsqrt_expected[$];

   // widen a binary32 word to a real, subnormals included
   function automatic real single_to_real(input logic [31:0] w);
      logic [63:0] d;
      real r;
      if (w[30:23] == 8'hff) begin
         d = {w[31], 11'h7ff, w[22:0], 29'b0};
         return $bitstoreal(d);
      end else if (w[30:23] == 8'h00) begin
         r = real'(w[22:0]) * (2.0 ** -149);
         return w[31] ? -r : r;
      end
      d = {w[31], 11'(int'(w[30:23]) - 127 + 1023), w[22:0], 29'b0};
      return $bitstoreal(d);
   endfunction

   // round a real to binary32, nearest even, with gradual underflow
   function automatic logic [31:0] real_to_single(input real r);
      logic [63:0] d, sig, q;
      int fe, sh;
      logic guard, sticky;
      d = $realtobits(r);
      if (d[62:52] == 11'h7ff)
         return {d[63], 8'hff, (d[51:0] != 0) ? 23'h400000 : 23'h0};
      if (d[62:52] == 11'h000) return {d[63], 31'b0};
      fe = int'(d[62:52]) - 1023 + 127;
      sig = {11'b0, 1'b1, d[51:0]};
      sh = (fe >= 1) ? 29 : 29 + (1 - fe);
      if (sh > 60) sh = 60;
      q = sig >> sh;
      guard = sig[sh - 1];
      sticky = (sig & ((64'd1 << (sh - 1)) - 1)) != 0;
      if (guard && (sticky || q[0])) q = q + 1;
      if (fe < 1) return {d[63], 31'(q)};
      if (q == 64'd1 << 24) begin
         q = q >> 1;
         fe = fe + 1;
      end
      if (fe >= 255) return {d[63], 8'hff, 23'h0};
      return {d[63], 8'(fe), q[22:0]};
   endfunction

   function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
      return real_to_single(single_to_real(a) * single_to_real(b));
   endfunction

   function automatic logic [31:0] predict_rsqrt(input logic [31:0] x);
      logic [31:0] halfx, g, t1, t2, t3, r;
      halfx = fmul(fir_pkg::ONE_HALF, x);
      g = fir_pkg::MAGIC - {x[31], x[31:1]};
      t1 = fmul(halfx, g);
      t2 = fmul(t1, g);
      t3 = real_to_single(single_to_real(fir_pkg::THREE_HALVES) - single_to_real(t2));
      r = fmul(g, t3);
      if (r[30:23] == 8'hff && r[22:0] != 0) r = fir_pkg::CANON_QNAN;
      return r;
   endfunction

   assign pending = rsqrt_expected.size();

   always @(posedge clock) begin
      logic [31:0] want;
      if (reset) begin
         rsqrt_expected.delete();
         errors <= 0;
         checked <= 0;
      end else begin
         if (rsp_strobe) begin
            if (rsqrt_expected.size() == 0) begin
               if (errors < 10)
                  $display("%0t: unexpected result %h", $realtime, rsp_result_bits);
               errors <= errors + 1;
            end else begin
               want = rsqrt_expected.pop_front();
               checked <= checked + 1;
               if (want !== rsp_result_bits) begin
                  if (errors < 10)
                     $display("%0t: result_bits expected %h got %h",
                              $realtime, want, rsp_result_bits);
                  errors <= errors + 1;
               end
            end
         end
         if (start && !busy) rsqrt_expected.push_back(predict_rsqrt(req_operand_bits));
      end
   end
endmodule

// ----- bench/tb.sv -----
// Top of the fast inverse square root testbench: clock, reset, stimulus and
// verdict. Depends on fir_pkg, fir_checker and the fast_inverse_sqrt RTL.
`timescale 1ns / 1ps
module tb;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [31:0] req_operand_bits = '0;
   logic        busy;
   logic        rsp_strobe;
   logic [31:0] rsp_result_bits;
   int          errors, pending, checked;

   always #4 clock = ~clock;

   fast_inverse_sqrt u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operand_bits(req_operand_bits),
      .rsp_strobe(rsp_strobe), .rsp_result_bits(rsp_result_bits)
   );

   fir_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operand_bits(req_operand_bits),
      .rsp_strobe(rsp_strobe), .rsp_result_bits(rsp_result_bits),
      .errors(errors), .pending(pending), .checked(checked)
   );

   // Present one word and hold it until the block takes it. With allow_idle
   // set, drop start for a random burst afterwards now and then.
   task automatic send_operand(input logic [31:0] w, input bit allow_idle);
      start <= 1'b1;
      req_operand_bits <= w;
      // busy is read at the falling edge so the decision is settled
      // before the rising edge that takes the word
      forever begin
         @(negedge clock);
         if (!busy) break;
      end
      @(posedge clock);
      if (allow_idle && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         req_operand_bits <= $urandom();
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   // Random operand: mostly well-formed positive floats over the whole
   // exponent range, plus raw noise and the special exponents.
   function automatic logic [31:0] random_operand();
      logic [31:0] w;
      w = $urandom();
      case ($urandom_range(0, 7))
         0, 1:    ; // raw bit pattern, any sign
         2:       w[30:23] = ($urandom_range(0, 1) == 1) ? 8'hff : 8'h00;
         3:       w[30:23] = 8'($urandom_range(100, 160));
         default: w[31] = 1'b0;
      endcase
      return w;
   endfunction

   initial begin
      logic [31:0] directed_words[$];
      int n;
      directed_words = '{
         32'h00000000, 32'h80000000, 32'h7f800000, 32'hff800000,
         32'h7fc00000, 32'h7f800001, 32'hffffffff, 32'h00000001,
         32'h00000002, 32'h007fffff, 32'h00800000, 32'h3f800000,
         32'h40800000, 32'h3e800000, 32'h7f7fffff, 32'hff7fffff,
         32'hbf800000, 32'h5f3759df, 32'hbe3759df, 32'h55555555,
         32'haaaaaaaa, 32'h7effffff, 32'h80000001
      };
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners back to back
      foreach (directed_words[i]) send_operand(directed_words[i], 1'b0);
      start <= 1'b0;

      // hold off until the pipe has drained completely
      while (pending != 0) @(posedge clock);
      @(posedge clock);

      // random words; the last stretch runs with no idling at all
      n = 930;
      for (int i = 0; i < n; i++) send_operand(random_operand(), i < n - 150);
      start <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (fir_pkg::LATENCY + 4) @(posedge clock);

      $display("Covered %0d operands: sign/zero/inf/NaN/subnormal corners and random words.",
               checked);
      $display("Idle bursts and a full drain were exercised; %0d mismatches.", errors);
      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #5ms;
      $display("Verification failed");
      $finish;
   end
endmodule
